// File: rtl/lane_line_intercept_clustering_top_macros.svh
// Assertion helpers shared by the RTL files.
`ifndef LANE_LINE_INTERCEPT_CLUSTERING_TOP_MACROS_SVH
`define LANE_LINE_INTERCEPT_CLUSTERING_TOP_MACROS_SVH

// Implication checked on every rising clock edge outside reset.
`define LLIC_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("llic check failed");

// Next-cycle implication checked outside reset.
`define LLIC_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("llic check failed");

`endif

// File: rtl/llic_pkg.sv
package llic_pkg;
  localparam int MAX_GROUPS = 16;
  localparam int COORD_BITS = 12;
  localparam int GIDX_W = $clog2(MAX_GROUPS);
  localparam int GCNT_W = $clog2(MAX_GROUPS + 1);
  localparam int SUM_W = 40;
  localparam int CNT_W = 12;
  localparam int X_W = 28;
  localparam int NUM_W = 48;
  localparam int DEN_W = COORD_BITS + 1;
  localparam logic [CNT_W-1:0] COUNT_MAX = '1;
  localparam int REG_IMAGE_ROWS = 0;
  localparam int REG_TOLERANCE = 1;

  typedef enum logic [1:0] {
    OUT_JOINED  = 2'd0,
    OUT_OPENED  = 2'd1,
    OUT_SKIPPED = 2'd2,
    OUT_DROPPED = 2'd3
  } outcome_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_DIV, ST_MUL, ST_WALK, ST_DONE
  } state_t;

  // Token travelling down the cell chain.
  typedef struct packed {
    logic              live;
    logic              found;
    logic [GIDX_W-1:0] idx;
    logic [CNT_W-1:0]  members;
  } token_t;
endpackage

// File: rtl/llic_cell.sv
module llic_cell (
  input  logic                            clk,
  input  logic                            clear,
  input  logic                            is_open,
  input  logic                            open_here,
  input  logic signed [llic_pkg::X_W-1:0] x,
  input  logic [9:0]                      tol,
  input  logic [llic_pkg::GIDX_W-1:0]     my_idx,
  input  llic_pkg::token_t                tok_in,
  output llic_pkg::token_t                tok_out
);
  import llic_pkg::*;

  logic signed [SUM_W-1:0] sum;
  logic [CNT_W-1:0] cnt;
  logic signed [SUM_W+CNT_W:0] prod;
  logic signed [SUM_W+CNT_W+1:0] diff;
  logic [SUM_W+CNT_W+11:0] lhs;
  logic signed [SUM_W+CNT_W+11:0] rhs;
  logic hit;
  token_t tok_next;

  always_comb begin
    prod = x * $signed({1'b0, cnt});
    diff = prod - sum;
    if (diff < 0) diff = -diff;
    lhs = {diff[SUM_W+CNT_W:0], 10'd0};
    rhs = $signed({1'b0, tol}) * sum;
    hit = is_open && tok_in.live && !tok_in.found && !rhs[SUM_W+CNT_W+11] &&
          (lhs <= $unsigned(rhs));
  end

  always_ff @(posedge clk) begin
    if (clear) begin
      sum <= '0;
      cnt <= '0;
    end else if (open_here) begin
      sum <= SUM_W'(x);
      cnt <= CNT_W'(1);
    end else if (hit && cnt != COUNT_MAX) begin
      sum <= sum + SUM_W'(x);
      cnt <= cnt + 1'b1;
    end
  end

  always_comb begin
    tok_next = tok_in;
    if (hit) begin
      tok_next.found = 1'b1;
      tok_next.idx = my_idx;
      tok_next.members = (cnt == COUNT_MAX) ? cnt : cnt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (clear) tok_out <= '0;
    else tok_out <= tok_next;
  end
endmodule

// File: rtl/llic_div.sv
module llic_div (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  input  logic signed [llic_pkg::NUM_W-1:0]  num,
  input  logic signed [llic_pkg::DEN_W-1:0]  den,
  output logic                               done,
  output logic signed [llic_pkg::X_W-1:0]    quo
);
  import llic_pkg::*;

  logic [NUM_W-1:0] q;
  logic [DEN_W:0] rem;
  logic [DEN_W-1:0] d;
  logic neg;
  logic [5:0] step;
  logic busy;
  logic [DEN_W+1:0] trial;
  logic signed [NUM_W:0] sq;

  always_comb begin
    trial = {rem, q[NUM_W-1]} - {2'b0, d};
    sq = neg ? -$signed({1'b0, q}) : $signed({1'b0, q});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= busy && (step == 6'd1);
      if (start) begin
        busy <= 1'b1;
        step <= 6'(NUM_W);
        q <= num[NUM_W-1] ? NUM_W'(-num) : num;
        d <= den[DEN_W-1] ? DEN_W'(-den) : den;
        rem <= '0;
        neg <= num[NUM_W-1] ^ den[DEN_W-1];
      end else if (busy) begin
        // one quotient bit a cycle, restoring
        if (!trial[DEN_W+1]) begin
          rem <= trial[DEN_W:0];
          q <= {q[NUM_W-2:0], 1'b1};
        end else begin
          rem <= {rem[DEN_W-1:0], q[NUM_W-1]};
          q <= {q[NUM_W-2:0], 1'b0};
        end
        step <= step - 1'b1;
        if (step == 6'd1) busy <= 1'b0;
      end
    end
  end

  always_comb begin
    if (sq > $signed((NUM_W+1)'(134217727))) quo = X_W'(134217727);
    else if (sq < -$signed((NUM_W+1)'(134217728))) quo = {1'b1, {(X_W-1){1'b0}}};
    else quo = sq[X_W-1:0];
  end

  `include "lane_line_intercept_clustering_top_macros.svh"
  `LLIC_ASSERT_IMP(a_no_restart, busy, !start)
  `LLIC_ASSERT_NXT(a_done_pulse, done, !done)
  `LLIC_ASSERT_NXT(a_start_busy, start, busy)
endmodule

// File: rtl/lane_line_intercept_clustering_top.sv
// Lane line intercept clustering.
// Input channel: one segment a beat (start_x/y, end_x/y, first_of_frame) on
// in_valid/in_ready. Output channel: one result a beat on out_valid/out_ready.
// Config: cfg_we with cfg_index 0 image_rows, 1 tolerance_q10, written while idle.
// A segment first forms the intercept numerator with a 13x13-bit and a 14x13-bit
// multiply, then a restoring divider produces one quotient bit a cycle. The
// result walks a chain of 16 group cells, one cell a cycle. A horizontal segment
// has its result valid the cycle after its input beat. One segment is in flight
// at a time; in_ready is low until its result has been taken.
// Reset closes all groups and restores image_rows 720, tolerance 154.
// first_of_frame clears all groups before the segment is handled.
// A stalled receiver holds the result in the output register, and the stall time
// adds to the segment time.
module lane_line_intercept_clustering_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [llic_pkg::COORD_BITS-1:0] start_x,
  input  logic [llic_pkg::COORD_BITS-1:0] start_y,
  input  logic [llic_pkg::COORD_BITS-1:0] end_x,
  input  logic [llic_pkg::COORD_BITS-1:0] end_y,
  input  logic        first_of_frame,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  outcome,
  output logic [llic_pkg::GIDX_W-1:0] group_index,
  output logic signed [llic_pkg::X_W-1:0] intercept,
  output logic [llic_pkg::CNT_W-1:0] group_members,
  output logic [llic_pkg::GCNT_W-1:0] groups_in_use,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [12:0] cfg_data
);
  import llic_pkg::*;

  state_t state, state_next;
  logic [12:0] image_rows;
  logic [9:0] tolerance_q10;
  logic signed [COORD_BITS:0] dx, dy;
  logic signed [COORD_BITS:0] x0;
  logic signed [COORD_BITS+1:0] y0r;
  logic signed [2*COORD_BITS+1:0] m1;
  logic signed [2*COORD_BITS+2:0] m2;
  logic signed [NUM_W-1:0] p1, p2;
  logic [GCNT_W-1:0] open_groups;
  logic [GIDX_W:0] walk;
  logic div_start, div_done, clear;
  logic busy_q;
  logic signed [X_W-1:0] xq, x;
  token_t chain [MAX_GROUPS+1];
  logic [MAX_GROUPS-1:0] is_open, open_here;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_rows <= 13'd720;
      tolerance_q10 <= 10'd154;
    end else if (cfg_we) begin
      if (cfg_index == 1'(REG_IMAGE_ROWS)) image_rows <= cfg_data;
      else tolerance_q10 <= cfg_data[9:0];
    end
  end

  assign in_ready = (state == ST_IDLE);
  assign clear = rst || (in_valid && in_ready && first_of_frame);

  assign m1 = x0 * dy;
  assign m2 = y0r * dx;

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      x0 <= {1'b0, start_x};
      dx <= $signed({1'b0, end_x}) - $signed({1'b0, start_x});
      dy <= $signed({1'b0, end_y}) - $signed({1'b0, start_y});
      y0r <= $signed({2'b0, start_y}) - $signed({1'b0, image_rows});
    end
    if (state == ST_MUL) begin
      p1 <= NUM_W'(m1);
      p2 <= NUM_W'(m2);
    end
  end

  llic_div u_div (
    .clk(clk), .rst(rst), .start(div_start),
    .num(NUM_W'((p1 - p2) <<< 4)), .den(dy),
    .done(div_done), .quo(xq)
  );

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    div_start = 1'b0;
    unique case (state)
      ST_IDLE: if (in_valid) state_next = (start_y == end_y) ? ST_DONE : ST_MUL;
      ST_MUL: begin
        state_next = ST_DIV;
      end
      ST_DIV: begin
        div_start = (walk == '0) && !div_done && !busy_q;
        if (div_done) state_next = ST_WALK;
      end
      ST_WALK: if (walk == (GIDX_W+1)'(MAX_GROUPS)) state_next = ST_DONE;
      ST_DONE: if (out_valid && out_ready) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) busy_q <= 1'b0;
    else if (state != ST_DIV) busy_q <= 1'b0;
    else if (div_start) busy_q <= 1'b1;
  end

  always_ff @(posedge clk) begin
    if (div_done) x <= xq;
    if (state != ST_WALK) walk <= '0;
    else walk <= walk + 1'b1;
  end

  always_comb begin
    chain[0] = '0;
    chain[0].live = (state == ST_WALK) && (walk == '0);
  end

  genvar g;
  generate
    for (g = 0; g < MAX_GROUPS; g++) begin : g_cell
      assign is_open[g] = (GCNT_W'(g) < open_groups);
      llic_cell u_cell (
        .clk(clk), .clear(clear), .is_open(is_open[g]),
        .open_here(open_here[g]), .x(x), .tol(tolerance_q10),
        .my_idx(GIDX_W'(g)), .tok_in(chain[g]), .tok_out(chain[g+1])
      );
    end
  endgenerate

  token_t last;
  assign last = chain[MAX_GROUPS];
  always_comb begin
    open_here = '0;
    if (last.live && !last.found && open_groups != GCNT_W'(MAX_GROUPS))
      open_here[open_groups[GIDX_W-1:0]] = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (clear) open_groups <= '0;
    else if (open_here != '0) open_groups <= open_groups + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (out_valid && out_ready) out_valid <= 1'b0;
    else if (state == ST_IDLE && in_valid && start_y == end_y) begin
      out_valid <= 1'b1;
      outcome <= OUT_SKIPPED;
      group_index <= '0;
      intercept <= '0;
      group_members <= '0;
      groups_in_use <= first_of_frame ? '0 : open_groups;
    end else if (last.live) begin
      out_valid <= 1'b1;
      intercept <= x;
      if (last.found) begin
        outcome <= OUT_JOINED;
        group_index <= last.idx;
        group_members <= last.members;
        groups_in_use <= open_groups;
      end else if (open_groups != GCNT_W'(MAX_GROUPS)) begin
        outcome <= OUT_OPENED;
        group_index <= open_groups[GIDX_W-1:0];
        group_members <= CNT_W'(1);
        groups_in_use <= open_groups + 1'b1;
      end else begin
        outcome <= OUT_DROPPED;
        group_index <= '0;
        group_members <= '0;
        groups_in_use <= open_groups;
      end
    end
  end

  `include "lane_line_intercept_clustering_top_macros.svh"
  `LLIC_ASSERT_IMP(a_ready_idle, in_ready, !out_valid)
  `LLIC_ASSERT_IMP(a_open_bound, 1'b1, open_groups <= GCNT_W'(MAX_GROUPS))
  `LLIC_ASSERT_IMP(a_open_onehot, 1'b1, $onehot0(open_here))
endmodule

// File: sim/lane_line_intercept_clustering_top_test.sv
`timescale 1ns / 1ps

module lane_line_intercept_clustering_top_test;
  import llic_pkg::*;

  typedef struct {
    logic [11:0] sx, sy, ex, ey;
    logic        fof;
  } segment_t;

  typedef struct {
    outcome_t    oc;
    logic [3:0]  gidx;
    logic [27:0] xint;
    logic [11:0] members;
    logic [4:0]  in_use;
  } cluster_result_t;

  localparam longint X_HI = 134217727;
  localparam longint X_LO = -134217728;
  localparam int IDLE_LIMIT = 3000;

  logic        clk = 0;
  logic        rst = 1;
  logic        in_valid = 0;
  logic        in_ready;
  logic [11:0] start_x = 0, start_y = 0, end_x = 0, end_y = 0;
  logic        first_of_frame = 0;
  logic        out_valid;
  logic        out_ready = 0;
  logic [1:0]  outcome;
  logic [3:0]  group_index;
  logic signed [27:0] intercept;
  logic [11:0] group_members;
  logic [4:0]  groups_in_use;
  logic        cfg_we = 0;
  logic        cfg_index = 0;
  logic [12:0] cfg_data = 0;

  lane_line_intercept_clustering_top DUT (.*);

  initial forever #10 clk = ~clk;

  // predictor state
  longint      grp_sum [MAX_GROUPS];
  int unsigned grp_cnt [MAX_GROUPS];
  int unsigned grp_open;
  int unsigned rows_cfg = 720;
  int unsigned tol_cfg = 154;

  segment_t        seg_queue[$];
  cluster_result_t result_queue[$];
  bit failed = 0;
  bit burst_in = 0, burst_out = 0;
  int in_gap = 0, out_stall = 0, idle_cycles = 0;

  function automatic cluster_result_t cluster_segment(segment_t s);
    cluster_result_t r;
    longint x0, y0, x1, y1, dx, dy, num, x, c, sm, diff;
    bit hit;
    x0 = s.sx; y0 = s.sy; x1 = s.ex; y1 = s.ey;
    dx = x1 - x0;
    dy = y1 - y0;
    x = 0;
    hit = 0;
    r.gidx = '0;
    r.members = '0;
    if (s.fof) begin
      for (int g = 0; g < MAX_GROUPS; g++) begin
        grp_sum[g] = 0;
        grp_cnt[g] = 0;
      end
      grp_open = 0;
    end
    if (dy == 0) begin
      r.oc = OUT_SKIPPED;
    end else begin
      num = 16 * (x0 * dy - (y0 - longint'(rows_cfg)) * dx);
      x = num / dy;
      if (x > X_HI) x = X_HI;
      if (x < X_LO) x = X_LO;
      for (int g = 0; g < grp_open && !hit; g++) begin
        c = grp_cnt[g];
        sm = grp_sum[g];
        diff = x * c - sm;
        if (diff < 0) diff = -diff;
        if (diff * 1024 <= longint'(tol_cfg) * sm) begin
          // a full group still matches but holds its average
          if (grp_cnt[g] < 4095) begin
            grp_sum[g] = sm + x;
            grp_cnt[g]++;
          end
          r.gidx = 4'(g);
          r.members = 12'(grp_cnt[g]);
          hit = 1;
        end
      end
      if (hit) begin
        r.oc = OUT_JOINED;
      end else if (grp_open < MAX_GROUPS) begin
        r.gidx = 4'(grp_open);
        grp_sum[grp_open] = x;
        grp_cnt[grp_open] = 1;
        grp_open++;
        r.members = 12'd1;
        r.oc = OUT_OPENED;
      end else begin
        r.oc = OUT_DROPPED;
      end
    end
    r.xint = x[27:0];
    r.in_use = 5'(grp_open);
    return r;
  endfunction

  function automatic int draw_gap(bit burst);
    return burst ? 0 : $urandom_range(0, 11);
  endfunction

  // driver
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) begin
        result_queue = {result_queue, cluster_segment('{start_x, start_y, end_x, end_y,
                                                        first_of_frame})};
        if ($urandom_range(0, 99) == 0) burst_in <= !burst_in;
        in_gap = draw_gap(burst_in);
      end
      if (!in_valid || in_ready) begin
        if (in_gap > 0) begin
          in_gap--;
          in_valid <= 0;
        end else if (seg_queue.size() > 0) begin
          segment_t s;
          s = seg_queue.pop_front();
          start_x <= s.sx;
          start_y <= s.sy;
          end_x <= s.ex;
          end_y <= s.ey;
          first_of_frame <= s.fof;
          in_valid <= 1;
        end else begin
          in_valid <= 0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (result_queue.size() == 0) begin
          $error("result beat with nothing expected");
          failed = 1;
        end else begin
          cluster_result_t e;
          e = result_queue.pop_front();
          if (outcome !== e.oc) begin
            $error("outcome expected %0d got %0d", e.oc, outcome); failed = 1;
          end
          if (group_index !== e.gidx) begin
            $error("group_index expected %0d got %0d", e.gidx, group_index); failed = 1;
          end
          if (intercept !== e.xint) begin
            $error("intercept expected %0d got %0d", $signed(e.xint), intercept);
            failed = 1;
          end
          if (group_members !== e.members) begin
            $error("group_members expected %0d got %0d", e.members, group_members);
            failed = 1;
          end
          if (groups_in_use !== e.in_use) begin
            $error("groups_in_use expected %0d got %0d", e.in_use, groups_in_use);
            failed = 1;
          end
        end
        if ($urandom_range(0, 99) == 0) burst_out <= !burst_out;
        out_stall = draw_gap(burst_out);
      end
      if (out_stall > 0) begin
        out_stall--;
        out_ready <= 0;
      end else begin
        out_ready <= 1;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("lane_line_intercept_clustering_top test failed");
        $finish;
      end
    end
  end

  task automatic add_seg(int sx, int sy, int ex, int ey, bit fof);
    segment_t s;
    s = '{sx[11:0], sy[11:0], ex[11:0], ey[11:0], fof};
    seg_queue = {seg_queue, s};
  endtask

  task automatic drain();
    do @(posedge clk);
    while (seg_queue.size() > 0 || in_valid || result_queue.size() > 0);
    // let a segment that is still walking finish before touching registers
    repeat (100) @(posedge clk);
  endtask

  task automatic set_regs(int rows, int tol);
    @(posedge clk);
    cfg_we <= 1;
    cfg_index <= 1'(REG_IMAGE_ROWS);
    cfg_data <= rows[12:0];
    @(posedge clk);
    cfg_index <= 1'(REG_TOLERANCE);
    cfg_data <= tol[12:0];
    @(posedge clk);
    cfg_we <= 0;
    rows_cfg = rows & 13'h1fff;
    tol_cfg = tol & 10'h3ff;
  endtask

  // one frame: jittered copies of a few base lines, plus horizontals and noise
  task automatic add_frame(int len, int lines);
    int bx0 [24], by0 [24], bx1 [24], by1 [24];
    int k, j, sel;
    for (k = 0; k < lines; k++) begin
      bx0[k] = $urandom_range(0, 4095);
      by0[k] = $urandom_range(0, 4095);
      bx1[k] = $urandom_range(0, 4095);
      by1[k] = $urandom_range(0, 4095);
    end
    for (j = 0; j < len; j++) begin
      sel = $urandom_range(0, 9);
      k = $urandom_range(0, lines - 1);
      if (sel < 7) begin
        add_seg(bx0[k] + $urandom_range(0, 6) - 3, by0[k] + $urandom_range(0, 6) - 3,
                bx1[k] + $urandom_range(0, 6) - 3, by1[k] + $urandom_range(0, 6) - 3,
                j == 0);
      end else if (sel == 7) begin
        k = $urandom_range(0, 4095);
        add_seg($urandom_range(0, 4095), k, $urandom_range(0, 4095), k, j == 0);
      end else begin
        add_seg($urandom_range(0, 4095), $urandom_range(0, 4095),
                $urandom_range(0, 4095), $urandom_range(0, 4095),
                j == 0 ? 1 : $urandom_range(0, 15) == 0);
      end
    end
  endtask

  task automatic random_phase(int items);
    int n;
    n = 0;
    while (n < items) begin
      int len;
      len = $urandom_range(3, 30);
      add_frame(len, $urandom_range(0, 3) == 0 ? $urandom_range(12, 24)
                                             : $urandom_range(1, 5));
      n += len;
    end
    drain();
  endtask

  initial begin
    int rows_set [6] = '{1, 4096, 8191, 0, 480, 720};
    int tol_set  [6] = '{0, 1023, 154, 512, 1, 154};
    for (int g = 0; g < MAX_GROUPS; g++) begin
      grp_sum[g] = 0;
      grp_cnt[g] = 0;
    end
    grp_open = 0;
    repeat (4) @(posedge clk);
    rst <= 0;

    // directed, reset register values
    add_seg(100, 0, 100, 500, 1);           // vertical
    add_seg(102, 10, 102, 400, 0);          // joins
    add_seg(0, 0, 4095, 0, 0);              // horizontal
    add_seg(0, 5, 0, 900, 1);               // vertical at zero, new frame
    add_seg(0, 3, 0, 4095, 0);              // zero sum matches zero
    add_seg(4095, 4095, 4095, 0, 0);
    add_seg(0, 4095, 4095, 4094, 0);        // saturates high
    add_seg(4095, 4095, 0, 4094, 0);        // saturates low
    add_seg(0, 4094, 4095, 4095, 0);
    add_seg(4095, 0, 0, 1, 0);
    add_seg(3000, 0, 2000, 700, 0);         // negative dx, leaning left
    add_seg(3005, 2, 2003, 701, 0);
    for (int i = 0; i < 14; i++)            // overflow the table
      add_seg(200 * i + 50, 0, 200 * i + 50, 100, 0);
    drain();

    for (int p = 0; p < 6; p++) begin
      set_regs(rows_set[p], tol_set[p]);
      random_phase(260);
    end

    if (!failed) begin
      $display("lane_line_intercept_clustering_top test passed");
    end else begin
      $display("lane_line_intercept_clustering_top test failed");
    end
    $finish;
  end

endmodule
